// ===== rtl/core/tctt_pkg.sv =====
// touch contact track table: shared types and codes
// word layouts for both channels, operation, life and register codes
package tctt_pkg;

  localparam int DATA_BITS = 16;
  localparam int ID_BITS   = 32;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DAT_W = 8;

  localparam logic [2:0] OP_BIRTH        = 3'd0;
  localparam logic [2:0] OP_BIRTH_RETAP  = 3'd1;
  localparam logic [2:0] OP_UPDATE       = 3'd2;
  localparam logic [2:0] OP_KILL         = 3'd3;
  localparam logic [2:0] OP_ENTER_GRACE  = 3'd4;
  localparam logic [2:0] OP_EXPIRE_GRACE = 3'd5;
  localparam logic [2:0] OP_RECYCLE      = 3'd6;
  localparam logic [2:0] OP_MARK_GESTURE = 3'd7;

  localparam logic [1:0] LIFE_DEAD   = 2'd0;
  localparam logic [1:0] LIFE_ACTIVE = 2'd1;
  localparam logic [1:0] LIFE_GRACE  = 2'd2;

  localparam logic STAT_DONE   = 1'b0;
  localparam logic STAT_REJECT = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_DEADZONE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLEND    = 1'd1;

  localparam logic [7:0] DEADZONE_RST = 8'd2;
  localparam logic [3:0] BLEND_RST    = 4'd5;
  localparam logic [3:0] BLEND_DEN    = 4'd8;

  typedef struct packed {
    logic [2:0]           operation;
    logic [3:0]           slot;
    logic [DATA_BITS-1:0] pos_x;
    logic [DATA_BITS-1:0] pos_y;
    logic [DATA_BITS-1:0] lift_x;
    logic [DATA_BITS-1:0] lift_y;
    logic                 solo_finger;
  } in_word_t;

  typedef struct packed {
    logic                 status;
    logic [ID_BITS-1:0]   contact_id;
    logic [DATA_BITS-1:0] out_x;
    logic [DATA_BITS-1:0] out_y;
  } out_word_t;

endpackage

// ===== rtl/core/tctt_filter.sv =====
// touch contact track table: position update filter
// deadzone against the baseline, then blend in eighths unless fresh or gesture-tainted; uses tctt_pkg
module tctt_filter import tctt_pkg::*; #(
  parameter int COORD_BITS = 16
) (
  input  logic [7:0]            deadzone,
  input  logic [3:0]            blend_num,
  input  logic                  fresh,
  input  logic                  gesture,
  input  logic                  solo,
  input  logic [COORD_BITS-1:0] px,
  input  logic [COORD_BITS-1:0] py,
  input  logic [COORD_BITS-1:0] rx,
  input  logic [COORD_BITS-1:0] ry,
  input  logic [COORD_BITS-1:0] bx,
  input  logic [COORD_BITS-1:0] by,
  output logic [COORD_BITS-1:0] rx_nxt,
  output logic [COORD_BITS-1:0] ry_nxt,
  output logic [COORD_BITS-1:0] bx_nxt,
  output logic [COORD_BITS-1:0] by_nxt,
  output logic                  gesture_nxt
);

  localparam int SW = COORD_BITS + 4;

  logic [COORD_BITS-1:0] adx, ady, dz;
  logic                  pass, taint;
  logic [3:0]            n, nc;
  logic [SW-1:0]         sum_x, sum_y;
  logic [COORD_BITS-1:0] blend_x, blend_y;

  assign dz    = COORD_BITS'(deadzone);
  assign adx   = (px >= bx) ? px - bx : bx - px;
  assign ady   = (py >= by) ? py - by : by - py;
  assign pass  = fresh || (deadzone == 8'd0) || (adx >= dz) || (ady >= dz);
  assign taint = gesture && solo;

  assign n     = (blend_num > BLEND_DEN) ? BLEND_DEN : blend_num;
  assign nc    = BLEND_DEN - n;
  assign sum_x = SW'(px) * SW'(n) + SW'(rx) * SW'(nc);
  assign sum_y = SW'(py) * SW'(n) + SW'(ry) * SW'(nc);
  assign blend_x = sum_x[COORD_BITS+2:3];
  assign blend_y = sum_y[COORD_BITS+2:3];

  always_comb begin
    rx_nxt      = rx;
    ry_nxt      = ry;
    bx_nxt      = bx;
    by_nxt      = by;
    gesture_nxt = gesture;
    if (pass) begin
      bx_nxt = px;
      by_nxt = py;
      if (fresh || taint) begin
        rx_nxt = px;
        ry_nxt = py;
        if (taint) begin
          gesture_nxt = 1'b0;
        end
      end else begin
        rx_nxt = blend_x;
        ry_nxt = blend_y;
      end
    end
  end

endmodule

// ===== rtl/core/touch_contact_track_table.sv =====
// touch contact track table: top level
// slot memory with read-modify-write sequencer; uses tctt_pkg, tctt_filter
//
//   port group   dir   handshake            word
//   in_          in    start / busy         in_word_t
//   out_         out   out_valid strobe     out_word_t
//   cfg_         in    cfg_we               cfg_idx, cfg_wdata
//
// each item is a read-modify-write: the slot entry is read in the accept cycle and
// modified and written back in the busy cycle, so no new word is accepted while busy.
// the result strobes in the cycle after the busy cycle, while the next word may
// already be accepted. reset clears the per-slot valid bits at once, so no clearing
// pass is needed. results cannot stall.
module touch_contact_track_table import tctt_pkg::*; #(
  parameter int SLOTS      = 16,
  parameter int COORD_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  in_word_t             in_word,
  output logic                 out_valid,
  output out_word_t            out_word,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [CFG_DAT_W-1:0] cfg_wdata
);

  localparam int CW      = COORD_BITS;
  localparam int SLOT_AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam logic [6:0] SLOTS_L = 7'(SLOTS);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RMW  = 1'b1;

  typedef struct packed {
    logic [1:0]         life;
    logic [ID_BITS-1:0] id;
    logic [CW-1:0]      rx;
    logic [CW-1:0]      ry;
    logic [CW-1:0]      bx;
    logic [CW-1:0]      by;
    logic               fresh;
    logic               gesture;
  } entry_t;

  entry_t               slot_mem [SLOTS];
  entry_t               rd_q_r;
  logic                 rd_vld_r;
  logic [SLOTS-1:0]     vld_r;
  logic                 state_r, state_nxt;
  in_word_t             req_r;
  logic [7:0]           dz_r;
  logic [3:0]           bn_r;
  logic [ID_BITS-1:0]   next_id_r, next_id_nxt;
  logic                 out_valid_r;
  out_word_t            out_word_r, out_word_nxt;

  logic                 accept;
  logic [SLOT_AW+3:0]   ra_ext, wa_ext;
  logic [SLOT_AW-1:0]   ra, wa;
  entry_t               cur, wdata;
  logic                 ok, in_rng, mem_we;
  logic [ID_BITS-1:0]   id_inc, id_new;
  logic [CW-1:0]        px, py, lx, ly;
  logic [CW-1:0]        f_rx, f_ry, f_bx, f_by;
  logic                 f_gesture;

  assign accept = start && (state_r == ST_IDLE);
  assign busy   = (state_r == ST_RMW);

  assign ra_ext = {{SLOT_AW{1'b0}}, in_word.slot};
  assign wa_ext = {{SLOT_AW{1'b0}}, req_r.slot};
  assign ra     = ra_ext[SLOT_AW-1:0];
  assign wa     = wa_ext[SLOT_AW-1:0];

  assign px = req_r.pos_x[CW-1:0];
  assign py = req_r.pos_y[CW-1:0];
  assign lx = req_r.lift_x[CW-1:0];
  assign ly = req_r.lift_y[CW-1:0];

  assign cur    = rd_vld_r ? rd_q_r : '0;
  assign in_rng = {3'b000, req_r.slot} < SLOTS_L;
  assign id_inc = next_id_r + ID_BITS'(1);
  assign id_new = (id_inc == '0) ? ID_BITS'(1) : id_inc;

  tctt_filter #(.COORD_BITS(CW)) u_filter (
    .deadzone    (dz_r),
    .blend_num   (bn_r),
    .fresh       (cur.fresh),
    .gesture     (cur.gesture),
    .solo        (req_r.solo_finger),
    .px          (px),
    .py          (py),
    .rx          (cur.rx),
    .ry          (cur.ry),
    .bx          (cur.bx),
    .by          (cur.by),
    .rx_nxt      (f_rx),
    .ry_nxt      (f_ry),
    .bx_nxt      (f_bx),
    .by_nxt      (f_by),
    .gesture_nxt (f_gesture)
  );

  always_comb begin
    ok = 1'b0;
    wdata = cur;
    out_word_nxt.status     = STAT_DONE;
    out_word_nxt.contact_id = cur.id;
    out_word_nxt.out_x      = DATA_BITS'(cur.rx);
    out_word_nxt.out_y      = DATA_BITS'(cur.ry);
    unique case (req_r.operation)
      OP_BIRTH, OP_BIRTH_RETAP: begin
        ok = (cur.life == LIFE_DEAD);
        wdata.life    = LIFE_ACTIVE;
        wdata.id      = id_new;
        wdata.rx      = (req_r.operation == OP_BIRTH) ? px : lx;
        wdata.ry      = (req_r.operation == OP_BIRTH) ? py : ly;
        wdata.bx      = wdata.rx;
        wdata.by      = wdata.ry;
        wdata.fresh   = (req_r.operation == OP_BIRTH);
        wdata.gesture = 1'b0;
        out_word_nxt.contact_id = id_new;
        out_word_nxt.out_x      = DATA_BITS'(wdata.rx);
        out_word_nxt.out_y      = DATA_BITS'(wdata.ry);
      end
      OP_UPDATE: begin
        ok = (cur.life == LIFE_ACTIVE);
        wdata.rx      = f_rx;
        wdata.ry      = f_ry;
        wdata.bx      = f_bx;
        wdata.by      = f_by;
        wdata.gesture = f_gesture;
        wdata.fresh   = 1'b0;
        out_word_nxt.out_x = DATA_BITS'(f_rx);
        out_word_nxt.out_y = DATA_BITS'(f_ry);
      end
      OP_KILL: begin
        ok = (cur.life == LIFE_ACTIVE) || (cur.life == LIFE_GRACE);
        wdata = '0;
      end
      OP_RECYCLE: begin
        ok = (cur.life == LIFE_ACTIVE) || (cur.life == LIFE_GRACE);
        wdata.life    = LIFE_ACTIVE;
        wdata.id      = id_new;
        wdata.rx      = px;
        wdata.ry      = py;
        wdata.bx      = px;
        wdata.by      = py;
        wdata.fresh   = 1'b1;
        wdata.gesture = 1'b0;
      end
      OP_ENTER_GRACE: begin
        ok = (cur.life == LIFE_ACTIVE);
        wdata.life = LIFE_GRACE;
      end
      OP_EXPIRE_GRACE: begin
        ok = (cur.life == LIFE_GRACE);
        wdata = '0;
        out_word_nxt.contact_id = '0;
        out_word_nxt.out_x      = '0;
        out_word_nxt.out_y      = '0;
      end
      OP_MARK_GESTURE: begin
        ok = (cur.life == LIFE_ACTIVE);
        wdata.gesture = 1'b1;
      end
      default: begin
        ok = 1'b0;
      end
    endcase
    if (!(ok && in_rng)) begin
      out_word_nxt = '0;
      out_word_nxt.status = STAT_REJECT;
    end
  end

  assign mem_we = busy && ok && in_rng;

  always_comb begin
    next_id_nxt = next_id_r;
    if (mem_we && ((req_r.operation == OP_BIRTH) || (req_r.operation == OP_BIRTH_RETAP) ||
                   (req_r.operation == OP_RECYCLE))) begin
      next_id_nxt = id_new;
    end
    state_nxt = accept ? ST_RMW : ST_IDLE;
  end

  // slot memory with registered read, request capture and result register
  always_ff @(posedge clk) begin
    if (mem_we) begin
      slot_mem[wa] <= wdata;
    end
    if (accept) begin
      rd_q_r <= slot_mem[ra];
      req_r  <= in_word;
    end
    if (busy) begin
      out_word_r <= out_word_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      vld_r       <= '0;
      rd_vld_r    <= 1'b0;
      next_id_r   <= '0;
      out_valid_r <= 1'b0;
      dz_r        <= DEADZONE_RST;
      bn_r        <= BLEND_RST;
    end else begin
      state_r     <= state_nxt;
      next_id_r   <= next_id_nxt;
      out_valid_r <= busy;
      if (mem_we) begin
        vld_r[wa] <= (wdata.life != LIFE_DEAD);
      end
      if (accept) begin
        rd_vld_r <= vld_r[ra];
      end
      if (cfg_we) begin
        unique case (cfg_idx)
          CFG_DEADZONE: dz_r <= cfg_wdata;
          CFG_BLEND:    bn_r <= cfg_wdata[3:0];
          default:      ;
        endcase
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  a_busy_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    busy |=> !busy)
    else $error("busy held longer than one cycle");

  a_accept_to_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted word did not start the update");

  a_result_follows_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result without an update cycle");

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(busy && out_valid))
    else $error("result strobe overlaps an update cycle");

  a_id_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (mem_we && (wdata.life == LIFE_ACTIVE)) |-> (wdata.id != '0))
    else $error("live slot written with contact id zero");

endmodule
